/* design/atma_pkg.sv */
`timescale 1ns / 1ps

package atma_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 8;
    localparam int MAX_STEPS           = 24;

    // Field widths
    localparam int ACC_W      = 16;
    localparam int MAG_W      = 16;
    localparam int PITCH_W    = 16;
    localparam int ROLL_W     = 17;
    localparam int TILT_W     = 16;
    localparam int STREAK_W   = 8;
    localparam int CNT_W      = 32;
    localparam int THR_W      = 16;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Fixed-point datapath
    localparam int GUARD_BITS = 8;
    localparam int ATAN_FRAC  = 16;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 22;
    localparam int XY_W       = 28;
    localparam int ANG_W      = 27;
    localparam int INVK_W     = 24;
    localparam int PROD_W     = XY_W - 1 + INVK_W;
    localparam logic [INVK_W-1:0] INVK_Q24 = 24'd10188014;
    localparam logic [MAG_W-1:0]  ONE_G    = 16'd16384;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]   RST_MOVING_THR  = 16'd4915;
    localparam logic [THR_W-1:0]   RST_TILT_THR    = 16'd7680;
    localparam logic [LIMIT_W-1:0] RST_ERROR_LIMIT = 8'd3;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ALARM = 2'd1,
        STAT_WARN  = 2'd2,
        STAT_ERROR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_GAIN1,
        S_SETUP2,
        S_PASS2,
        S_GAIN2,
        S_FINISH,
        S_PUBLISH
    } t_state;

    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [ATAN_IDX_W-1:0] step_idx;
        logic                  mul;
        logic                  setup2;
        logic                  finish;
        logic                  publish;
    } t_dp_cmd;

    typedef struct packed {
        logic good_read;
        logic out_free;
    } t_dp_sts;

    // atan(2^-i) in 1/65536 degree, rounded
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/atma_in_if.sv */
`timescale 1ns / 1ps

interface atma_in_if;
    import atma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    read_ok;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;

    modport source (output valid, read_ok, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, read_ok, accel_x, accel_y, accel_z, output ready);
endinterface

/* design/atma_out_if.sv */
`timescale 1ns / 1ps

interface atma_out_if;
    import atma_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic                      moving;
    logic                      tilt_alarm;
    logic [MAG_W-1:0]          magnitude;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ROLL_W-1:0]  roll;
    logic [TILT_W-1:0]         tilt;
    logic [STREAK_W-1:0]       error_streak;
    logic [CNT_W-1:0]          valid_count;
    logic [CNT_W-1:0]          failed_count;

    modport source (output valid, status, moving, tilt_alarm, magnitude, pitch, roll, tilt,
                    error_streak, valid_count, failed_count, input ready);
    modport sink   (input valid, status, moving, tilt_alarm, magnitude, pitch, roll, tilt,
                    error_streak, valid_count, failed_count, output ready);
endinterface

/* design/atma_ctrl.sv */
`timescale 1ns / 1ps

module atma_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atma_pkg::t_dp_sts  i_sts,
    output atma_pkg::t_dp_cmd  o_cmd
);
    import atma_pkg::*;

    localparam int NSTEP  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              last_step;

    assign last_step = (r_step == LAST_STEP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.good_read ? S_PASS1 : S_PUBLISH;
                end
            end
            S_PASS1:   if (last_step) n_state = S_GAIN1;
            S_GAIN1:   n_state = S_SETUP2;
            S_SETUP2:  n_state = S_PASS2;
            S_PASS2:   if (last_step) n_state = S_GAIN2;
            S_GAIN2:   n_state = S_FINISH;
            S_FINISH:  n_state = S_PUBLISH;
            S_PUBLISH: if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.step_idx   = ATAN_IDX_W'(r_step);
        n_step           = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PASS1, S_PASS2: begin
                o_cmd.step = 1'b1;
                n_step     = last_step ? '0 : r_step + 1'b1;
            end
            S_GAIN1, S_GAIN2: o_cmd.mul = 1'b1;
            S_SETUP2:         o_cmd.setup2 = 1'b1;
            S_FINISH:         o_cmd.finish = 1'b1;
            S_PUBLISH:        o_cmd.publish = i_sts.out_free;
            default:          o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* design/atma_dp.sv */
`timescale 1ns / 1ps

module atma_dp #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atma_pkg::t_dp_cmd                   i_cmd,
    output atma_pkg::t_dp_sts                   o_sts,
    input  logic                                i_read_ok,
    input  logic signed [atma_pkg::ACC_W-1:0]   i_accel_x,
    input  logic signed [atma_pkg::ACC_W-1:0]   i_accel_y,
    input  logic signed [atma_pkg::ACC_W-1:0]   i_accel_z,
    input  logic [atma_pkg::THR_W-1:0]          i_moving_thr,
    input  logic [atma_pkg::THR_W-1:0]          i_tilt_thr,
    input  logic [atma_pkg::LIMIT_W-1:0]        i_error_limit,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output atma_pkg::t_status                   o_status,
    output logic                                o_moving,
    output logic                                o_tilt_alarm,
    output logic [atma_pkg::MAG_W-1:0]          o_magnitude,
    output logic signed [atma_pkg::PITCH_W-1:0] o_pitch,
    output logic signed [atma_pkg::ROLL_W-1:0]  o_roll,
    output logic [atma_pkg::TILT_W-1:0]         o_tilt,
    output logic [atma_pkg::STREAK_W-1:0]       o_error_streak,
    output logic [atma_pkg::CNT_W-1:0]          o_valid_count,
    output logic [atma_pkg::CNT_W-1:0]          o_failed_count
);
    import atma_pkg::*;

    localparam int RND_S     = ATAN_FRAC - ANGLE_FRAC_BITS;
    localparam int GAIN_SH1  = INVK_W;
    localparam int GAIN_SH2  = INVK_W + GUARD_BITS;
    localparam int MAG_FW    = PROD_W - GAIN_SH2;
    localparam logic signed [ANG_W-1:0] RND_HALF  = ANG_W'(64'sd1 <<< (RND_S - 1));
    localparam logic signed [ANG_W-1:0] ROLL_LIM  = ANG_W'(64'sd180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] PITCH_LIM = ANG_W'(64'sd90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_180   = ANG_W'(64'sd180 <<< ATAN_FRAC);
    localparam logic [PROD_W-1:0] G1_HALF = PROD_W'(64'd1 << (GAIN_SH1 - 1));
    localparam logic [PROD_W-1:0] G2_HALF = PROD_W'(64'd1 << (GAIN_SH2 - 1));
    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    // CORDIC working registers
    logic signed [XY_W-1:0]   r_x, r_y;
    logic signed [ANG_W-1:0]  r_ang;
    logic                     r_skip;
    logic signed [ACC_W-1:0]  r_ax;
    logic [PROD_W-1:0]        r_prod;
    logic signed [ANG_W-1:0]  r_roll;

    // Held state
    logic [MAG_W-1:0]         r_held_mag;
    logic [PITCH_W-1:0]       r_held_pitch;
    logic [ROLL_W-1:0]        r_held_roll;
    logic [TILT_W-1:0]        r_held_tilt;
    logic [1:0]               r_held_flags;
    logic [STREAK_W-1:0]      r_streak;
    logic [CNT_W-1:0]         r_good, r_bad;
    t_status                  r_status;

    // Load
    logic signed [XY_W-1:0]   sc_y, sc_z, ld_x, ld_y;
    logic signed [ANG_W-1:0]  ld_ang;
    logic                     neg_z;
    logic [STREAK_W-1:0]      streak_inc;

    // Step
    logic signed [XY_W-1:0]   sh_x, sh_y;
    logic signed [ANG_W-1:0]  atan_v;
    logic                     y_pos;

    // Rounding and gain
    logic signed [ANG_W-1:0]  rnd, roll_c, pitch_c, abs_p, abs_r, tilt_w;
    logic [PROD_W-1:0]        g1_sum, g2_sum;
    logic signed [XY_W-1:0]   x2, y2;
    logic [MAG_FW-1:0]        mag_w;
    logic [MAG_W-1:0]         mag, dev;
    logic                     mv, ta;

    assign neg_z  = i_accel_z[ACC_W-1];
    assign sc_y   = XY_W'(i_accel_y) <<< GUARD_BITS;
    assign sc_z   = XY_W'(i_accel_z) <<< GUARD_BITS;
    assign ld_x   = neg_z ? -sc_z : sc_z;
    assign ld_y   = neg_z ? -sc_y : sc_y;
    assign ld_ang = !neg_z ? '0 : (i_accel_y[ACC_W-1] ? -ANG_180 : ANG_180);
    assign streak_inc = (r_streak == STREAK_MAX) ? r_streak : r_streak + 1'b1;

    assign sh_x   = r_x >>> i_cmd.step_idx;
    assign sh_y   = r_y >>> i_cmd.step_idx;
    assign atan_v = $signed({{(ANG_W - ATAN_W){1'b0}}, atan_lut(i_cmd.step_idx)});
    assign y_pos  = !r_y[XY_W-1];

    // Round half up to the output grid, then clamp to the angle's range
    assign rnd = (r_ang + RND_HALF) >>> RND_S;
    always_comb begin
        roll_c = rnd;
        if (rnd > ROLL_LIM) roll_c = ROLL_LIM;
        if (rnd < -ROLL_LIM) roll_c = -ROLL_LIM;
        pitch_c = rnd;
        if (rnd > PITCH_LIM) pitch_c = PITCH_LIM;
        if (rnd < -PITCH_LIM) pitch_c = -PITCH_LIM;
    end

    assign g1_sum = r_prod + G1_HALF;
    assign x2     = XY_W'({1'b0, g1_sum[PROD_W-1:GAIN_SH1]});
    assign y2     = -(XY_W'(r_ax) <<< GUARD_BITS);

    assign g2_sum = r_prod + G2_HALF;
    assign mag_w  = g2_sum[PROD_W-1:GAIN_SH2];
    assign mag    = (|mag_w[MAG_FW-1:MAG_W]) ? '1 : mag_w[MAG_W-1:0];
    assign dev    = (mag >= ONE_G) ? mag - ONE_G : ONE_G - mag;
    assign mv     = (dev >= i_moving_thr);

    assign abs_p  = pitch_c[ANG_W-1] ? -pitch_c : pitch_c;
    assign abs_r  = r_roll[ANG_W-1] ? -r_roll : r_roll;
    assign tilt_w = (abs_p > abs_r) ? abs_p : abs_r;
    assign ta     = ($unsigned(tilt_w) >= {{(ANG_W - THR_W){1'b0}}, i_tilt_thr});

    assign o_sts.good_read = i_read_ok;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= ld_x;
            r_y    <= ld_y;
            r_ang  <= ld_ang;
            r_skip <= (ld_x == '0) && (ld_y == '0);
            r_ax   <= i_accel_x;
        end else if (i_cmd.step) begin
            if (!r_skip) begin
                if (y_pos) begin
                    r_x   <= r_x + sh_y;
                    r_y   <= r_y - sh_x;
                    r_ang <= r_ang + atan_v;
                end else begin
                    r_x   <= r_x - sh_y;
                    r_y   <= r_y + sh_x;
                    r_ang <= r_ang - atan_v;
                end
            end
        end else if (i_cmd.setup2) begin
            r_x    <= x2;
            r_y    <= y2;
            r_ang  <= '0;
            r_skip <= (x2 == '0) && (y2 == '0);
            r_roll <= roll_c;
        end
        // x never goes negative in vectoring, so the sign bit can be dropped
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_x[XY_W-2:0]) * PROD_W'(INVK_Q24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_mag   <= '0;
            r_held_pitch <= '0;
            r_held_roll  <= '0;
            r_held_tilt  <= '0;
            r_held_flags <= '0;
            r_streak     <= '0;
            r_good       <= '0;
            r_bad        <= '0;
            r_status     <= STAT_OK;
        end else if (i_cmd.load && !i_read_ok) begin
            r_bad    <= r_bad + 1'b1;
            r_streak <= streak_inc;
            r_status <= (streak_inc >= i_error_limit) ? STAT_ERROR : STAT_WARN;
        end else if (i_cmd.finish) begin
            r_held_mag   <= mag;
            r_held_pitch <= pitch_c[PITCH_W-1:0];
            r_held_roll  <= r_roll[ROLL_W-1:0];
            r_held_tilt  <= tilt_w[TILT_W-1:0];
            r_held_flags <= {ta, mv};
            r_streak     <= '0;
            r_good       <= r_good + 1'b1;
            r_status     <= (mv || ta) ? STAT_ALARM : STAT_OK;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_status       <= r_status;
            o_moving       <= r_held_flags[0];
            o_tilt_alarm   <= r_held_flags[1];
            o_magnitude    <= r_held_mag;
            o_pitch        <= $signed(r_held_pitch);
            o_roll         <= $signed(r_held_roll);
            o_tilt         <= r_held_tilt;
            o_error_streak <= r_streak;
            o_valid_count  <= r_good;
            o_failed_count <= r_bad;
        end
    end

endmodule

/* design/accel_tilt_motion_alarm.sv */
`timescale 1ns / 1ps

// Accelerometer tilt and motion alarm. Each transfer on i_in is one sensor
// read; each read yields exactly one result on o_out. A good read runs two
// CORDIC vectoring passes on one shared step unit (roll and |yz| first, then
// pitch and magnitude), each followed by a gain-removal multiply; a failed
// read skips both passes. Reads are handled one at a time; the next read is
// accepted as soon as the result sits in the output register, even if it has
// not yet been taken. Thresholds and the error limit are written through
// i_cfg_*; write them only while no read is in flight, which the block itself
// does not enforce.
module accel_tilt_motion_alarm #(
    parameter int CORDIC_STEPS    = atma_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = atma_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [atma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [atma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    atma_in_if.sink                             i_in,
    atma_out_if.source                          o_out
);
    import atma_pkg::*;

    logic [THR_W-1:0]   r_moving_thr;
    logic [THR_W-1:0]   r_tilt_thr;
    logic [LIMIT_W-1:0] r_error_limit;
    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving_thr  <= RST_MOVING_THR;
            r_tilt_thr    <= RST_TILT_THR;
            r_error_limit <= RST_ERROR_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOVING_THR:  r_moving_thr  <= i_cfg_data[THR_W-1:0];
                CFG_TILT_THR:    r_tilt_thr    <= i_cfg_data[THR_W-1:0];
                CFG_ERROR_LIMIT: r_error_limit <= i_cfg_data[LIMIT_W-1:0];
                default:         r_error_limit <= r_error_limit;
            endcase
        end
    end

    atma_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    atma_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_read_ok      (i_in.read_ok),
        .i_accel_x      (i_in.accel_x),
        .i_accel_y      (i_in.accel_y),
        .i_accel_z      (i_in.accel_z),
        .i_moving_thr   (r_moving_thr),
        .i_tilt_thr     (r_tilt_thr),
        .i_error_limit  (r_error_limit),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_moving       (o_out.moving),
        .o_tilt_alarm   (o_out.tilt_alarm),
        .o_magnitude    (o_out.magnitude),
        .o_pitch        (o_out.pitch),
        .o_roll         (o_out.roll),
        .o_tilt         (o_out.tilt),
        .o_error_streak (o_out.error_streak),
        .o_valid_count  (o_out.valid_count),
        .o_failed_count (o_out.failed_count)
    );

    // One read at a time: no second accept right after a transfer in
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while a read is in flight");

    // A good-read result carries a cleared streak, a failed-read result does not
    a_streak_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.status == STAT_OK || o_out.status == STAT_ALARM)
                         == (o_out.error_streak == '0)))
        else $error("status disagrees with error streak");

    // On a good read, ALARM exactly when a flag is raised
    a_alarm_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.error_streak == '0)
            |-> ((o_out.status == STAT_ALARM) == (o_out.moving || o_out.tilt_alarm)))
        else $error("alarm status disagrees with flags");

endmodule

/* tb/accel_tilt_motion_alarm_tb.sv */
`timescale 1ns / 1ps

module accel_tilt_motion_alarm_tb;
    import atma_pkg::*;

    localparam int     STEPS_CFG     = 16;
    localparam int     ANGLE_FRAC    = 8;
    localparam int     STEP_COUNT    = (STEPS_CFG > 24) ? 24 : STEPS_CFG;
    localparam int     GUARD_SHIFT   = 8;
    localparam int     ATAN_SHIFT    = 16;
    localparam longint GUARD_SCALE   = 256;
    localparam longint GAIN_INV_Q24  = 10188014;
    localparam longint ONE_G_RAW     = 16384;
    localparam longint HALF_TURN     = longint'(180) <<< ATAN_SHIFT;
    localparam int     SETTLE_CYCLES = 2 * STEPS_CFG + 10;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic                    read_ok;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } t_read;

    typedef struct {
        t_status                   status;
        logic                      moving;
        logic                      tilt_alarm;
        logic [MAG_W-1:0]          magnitude;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
        logic [TILT_W-1:0]         tilt;
        logic [STREAK_W-1:0]       error_streak;
        logic [CNT_W-1:0]          valid_count;
        logic [CNT_W-1:0]          failed_count;
    } t_report;

    class tilt_alarm_tracker;
        bit [THR_W-1:0]            moving_thr;
        bit [THR_W-1:0]            tilt_thr;
        bit [LIMIT_W-1:0]          err_limit;
        bit [STREAK_W-1:0]         streak;
        bit [CNT_W-1:0]            good_reads;
        bit [CNT_W-1:0]            bad_reads;
        bit [MAG_W-1:0]            held_mag;
        bit signed [PITCH_W-1:0]   held_pitch;
        bit signed [ROLL_W-1:0]    held_roll;
        bit [TILT_W-1:0]           held_tilt;
        bit                        held_moving;
        bit                        held_tilt_alarm;
        longint                    atan_step [24];
        t_report                   reports_due [$];
        int                        n_mismatch;

        function new();
            moving_thr = RST_MOVING_THR;
            tilt_thr   = RST_TILT_THR;
            err_limit  = RST_ERROR_LIMIT;
            atan_step  = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};
        endfunction

        // Rotate (x, y) onto the positive x axis, summing the angle turned.
        function void rotate_to_axis(inout longint x, inout longint y, inout longint a);
            longint dx, dy;
            int     i;
            if (x == 0 && y == 0) return;
            for (i = 0; i < STEP_COUNT; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                    a += atan_step[i];
                end else begin
                    x -= dx;
                    y += dy;
                    a -= atan_step[i];
                end
            end
        endfunction

        function longint round_angle(longint a, longint lim);
            longint r;
            r = (a + (longint'(1) <<< (ATAN_SHIFT - ANGLE_FRAC - 1)))
                >>> (ATAN_SHIFT - ANGLE_FRAC);
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function longint drop_gain(longint x, int s);
            return (x * GAIN_INV_Q24 + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function void note_read(t_read r);
            longint  x, y, ang, roll_a, pitch_a, mag, abs_p, abs_r, tilt_a, dev;
            t_report rep;
            if (r.read_ok) begin
                x   = longint'(r.az) * GUARD_SCALE;
                y   = longint'(r.ay) * GUARD_SCALE;
                ang = 0;
                // flip into the right half plane first
                if (r.az < 0) begin
                    x   = -x;
                    y   = -y;
                    ang = (r.ay >= 0) ? HALF_TURN : -HALF_TURN;
                end
                rotate_to_axis(x, y, ang);
                roll_a = round_angle(ang, longint'(180) <<< ANGLE_FRAC);
                x   = drop_gain(x, 24);
                y   = -longint'(r.ax) * GUARD_SCALE;
                ang = 0;
                rotate_to_axis(x, y, ang);
                pitch_a = round_angle(ang, longint'(90) <<< ANGLE_FRAC);
                mag = drop_gain(x, 24 + GUARD_SHIFT);
                if (mag > 65535) mag = 65535;
                abs_p  = (pitch_a < 0) ? -pitch_a : pitch_a;
                abs_r  = (roll_a < 0) ? -roll_a : roll_a;
                tilt_a = (abs_p > abs_r) ? abs_p : abs_r;
                dev    = mag - ONE_G_RAW;
                if (dev < 0) dev = -dev;
                good_reads++;
                streak          = '0;
                held_mag        = MAG_W'(mag);
                held_pitch      = PITCH_W'(pitch_a);
                held_roll       = ROLL_W'(roll_a);
                held_tilt       = TILT_W'(tilt_a);
                held_moving     = dev >= longint'(moving_thr);
                held_tilt_alarm = tilt_a >= longint'(tilt_thr);
                rep.status = (held_moving || held_tilt_alarm) ? STAT_ALARM : STAT_OK;
            end else begin
                bad_reads++;
                if (streak != 8'hFF) streak++;
                rep.status = (streak >= err_limit) ? STAT_ERROR : STAT_WARN;
            end
            rep.moving       = held_moving;
            rep.tilt_alarm   = held_tilt_alarm;
            rep.magnitude    = held_mag;
            rep.pitch        = held_pitch;
            rep.roll         = held_roll;
            rep.tilt         = held_tilt;
            rep.error_streak = streak;
            rep.valid_count  = good_reads;
            rep.failed_count = bad_reads;
            reports_due.push_back(rep);
        endfunction

        function void field_check(string name, longint want, longint got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                n_mismatch++;
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (reports_due.size() == 0) begin
                $error("result transfer with no read pending");
                n_mismatch++;
                return;
            end
            want = reports_due.pop_front();
            field_check("status", longint'(want.status), longint'(got.status));
            field_check("moving", longint'(want.moving), longint'(got.moving));
            field_check("tilt_alarm", longint'(want.tilt_alarm), longint'(got.tilt_alarm));
            field_check("magnitude", longint'(want.magnitude), longint'(got.magnitude));
            field_check("pitch", longint'(want.pitch), longint'(got.pitch));
            field_check("roll", longint'(want.roll), longint'(got.roll));
            field_check("tilt", longint'(want.tilt), longint'(got.tilt));
            field_check("error_streak", longint'(want.error_streak),
                        longint'(got.error_streak));
            field_check("valid_count", longint'(want.valid_count), longint'(got.valid_count));
            field_check("failed_count", longint'(want.failed_count),
                        longint'(got.failed_count));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    idle_pct = 28;
    bit                    hold_req;
    int                    cycle_count;
    tilt_alarm_tracker     tracker = new();

    atma_in_if  rd_if ();
    atma_out_if rpt_if ();

    accel_tilt_motion_alarm #(
        .CORDIC_STEPS   (STEPS_CFG),
        .ANGLE_FRAC_BITS(ANGLE_FRAC)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (rd_if),
        .o_out     (rpt_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("accel_tilt_motion_alarm verification failed");
            $finish;
        end
    end

    function automatic t_read mk_read(input bit ok, input int ax, input int ay, input int az);
        t_read r;
        r.read_ok = ok;
        r.ax      = ACC_W'(ax);
        r.ay      = ACC_W'(ay);
        r.az      = ACC_W'(az);
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] rand_axis(input int kind);
        case (kind)
            0, 1: return ACC_W'($urandom);
            2:    return ACC_W'(int'($urandom_range(128)) - 64);
            3: begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return -16'sd1;
                    2:       return 16'sd0;
                    3:       return 16'sd1;
                    default: return 16'sh7FFF;
                endcase
            end
            default: return ACC_W'(int'($urandom_range(36000)) - 18000);
        endcase
    endfunction

    function automatic t_read rand_read(input bit ok);
        t_read r;
        int    kind;
        kind      = $urandom_range(9);
        r.read_ok = ok;
        r.ax      = rand_axis(kind);
        r.ay      = rand_axis(kind);
        r.az      = rand_axis(kind);
        return r;
    endfunction

    // Offer one read, idling at random first; return at the transfer edge.
    task automatic send_read(input t_read r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rd_if.valid   <= 1'b1;
        rd_if.read_ok <= r.read_ok;
        rd_if.accel_x <= r.ax;
        rd_if.accel_y <= r.ay;
        rd_if.accel_z <= r.az;
        do @(posedge i_clk); while (!rd_if.ready);
        tracker.note_read(r);
    endtask

    task automatic drain_results();
        while (tracker.reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] mov,
                                  input logic [CFG_DATA_W-1:0] tlt,
                                  input logic [CFG_DATA_W-1:0] lim);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    k;
        idx = '{CFG_MOVING_THR, CFG_TILT_THR, CFG_UNUSED, CFG_ERROR_LIMIT};
        val = '{mov, tlt, CFG_DATA_W'($urandom), lim};
        for (k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            case (idx[k])
                CFG_MOVING_THR:  tracker.moving_thr = val[k];
                CFG_TILT_THR:    tracker.tilt_thr   = val[k];
                CFG_ERROR_LIMIT: tracker.err_limit  = val[k][LIMIT_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_reads, input bit long_fail_run);
        int sent, run;
        sent = 0;
        while (sent < n_reads) begin
            if (long_fail_run && sent >= 40) begin
                run           = 260;
                long_fail_run = 1'b0;
            end else if ($urandom_range(99) < 12) begin
                run = $urandom_range(1, 6);
            end else begin
                run = 0;
            end
            if (run == 0) begin
                send_read(rand_read(1'b1));
                sent++;
            end else begin
                repeat (run) begin
                    send_read(rand_read(1'b0));
                    sent++;
                end
            end
        end
        rd_if.valid <= 1'b0;
    endtask

    // Result side: check each transfer, stall at random or on request.
    initial begin
        int      hold_left;
        t_report got;
        hold_left    = 0;
        rpt_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rpt_if.valid && rpt_if.ready) begin
                got.status       = rpt_if.status;
                got.moving       = rpt_if.moving;
                got.tilt_alarm   = rpt_if.tilt_alarm;
                got.magnitude    = rpt_if.magnitude;
                got.pitch        = rpt_if.pitch;
                got.roll         = rpt_if.roll;
                got.tilt         = rpt_if.tilt;
                got.error_streak = rpt_if.error_streak;
                got.valid_count  = rpt_if.valid_count;
                got.failed_count = rpt_if.failed_count;
                tracker.check_report(got);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rpt_if.ready <= 1'b0;
            end else begin
                rpt_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin
        int k;
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        rd_if.valid   = 1'b0;
        rd_if.read_ok = 1'b0;
        rd_if.accel_x = '0;
        rd_if.accel_y = '0;
        rd_if.accel_z = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector, axis extremes, half-turn start on negative z
        send_read(mk_read(1'b1, 0, 0, 0));
        send_read(mk_read(1'b1, 0, 0, 16384));
        send_read(mk_read(1'b1, 0, 0, -16384));
        send_read(mk_read(1'b1, 0, -1, -16384));
        send_read(mk_read(1'b1, 0, 0, -1));
        send_read(mk_read(1'b1, 32767, 32767, 32767));
        send_read(mk_read(1'b1, -32768, -32768, -32768));
        send_read(mk_read(1'b1, -32768, 0, 0));
        send_read(mk_read(1'b1, 32767, 0, 0));
        send_read(mk_read(1'b1, 0, 32767, 0));
        send_read(mk_read(1'b1, 0, -32768, 0));
        send_read(mk_read(1'b1, 1, 0, 0));
        send_read(mk_read(1'b1, 0, 0, 1));
        // failed streak past the limit, then a good read clears it
        for (k = 0; k < 4; k++) send_read(mk_read(1'b0, 32767, -32768, 12345));
        send_read(mk_read(1'b1, 0, 16384, 16384));
        rd_if.valid <= 1'b0;
        drain_results();

        apply_settings(16'd0, 16'd0, 16'd1);
        random_phase(230, 1'b0);
        drain_results();

        // upper extremes, with a failed run long enough to saturate the streak
        apply_settings(16'hFFFF, 16'd46080, 16'hFFFF);
        random_phase(230, 1'b1);
        drain_results();

        // zero error limit: every failed read is an error
        apply_settings(RST_MOVING_THR, RST_TILT_THR, 16'd0);
        random_phase(230, 1'b0);
        drain_results();

        idle_pct = 0;
        apply_settings(CFG_DATA_W'($urandom_range(8000)), CFG_DATA_W'($urandom_range(46080)),
                       CFG_DATA_W'($urandom));
        random_phase(230, 1'b0);
        drain_results();

        idle_pct = 28;
        apply_settings(CFG_DATA_W'($urandom_range(8000)), CFG_DATA_W'($urandom_range(46080)),
                       CFG_DATA_W'($urandom));
        hold_req = 1'b1;
        random_phase(230, 1'b0);
        drain_results();

        apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(46080)),
                       CFG_DATA_W'($urandom_range(1, 8)));
        random_phase(230, 1'b0);
        drain_results();

        if (tracker.n_mismatch == 0 && tracker.reports_due.size() == 0)
            $display("accel_tilt_motion_alarm verification clean");
        else
            $display("accel_tilt_motion_alarm verification failed");
        $finish;
    end

endmodule
